[sv/terminator_span_update_top_defines.svh]
// assertion macros shared by the block's checker
`ifndef TERMINATOR_SPAN_UPDATE_TOP_DEFINES_SVH
`define TERMINATOR_SPAN_UPDATE_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define TSU_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define TSU_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/tsu_pkg.sv]
// shared constants and types of the terminator span update block
package tsu_pkg;

    // field widths
    localparam int unsigned LINE_W     = 9;
    localparam int unsigned HW_W       = 11;
    localparam int unsigned COL_W      = 10;
    localparam int unsigned CFG_W      = 11;
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 32;

    // map geometry
    localparam int unsigned MAP_HEIGHT_DEF  = 512;
    localparam int unsigned MAX_MAP_WIDTH   = 1024;
    localparam int unsigned MIN_MAP_WIDTH   = 2;
    localparam int unsigned MAP_WIDTH_RESET = 640;

    // width of column positions, which stay below twice the map width
    localparam int unsigned PW = $clog2(2 * MAX_MAP_WIDTH);

    // depth of the job queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    // one classified line: up to two runs, each may wrap into two segments
    typedef struct packed {
        logic [LINE_W-1:0] line;
        logic [PW-1:0]     left0;
        logic [PW-1:0]     npix0;
        logic [PW-1:0]     left1;
        logic [PW-1:0]     npix1;
        logic              two;
    } tsu_job_t;

endpackage

[sv/tsu_front.sv]
// front end: span table, clamping and classification of each line into runs
module tsu_front #(
    parameter int unsigned MAP_HEIGHT = tsu_pkg::MAP_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [tsu_pkg::PW-1:0]          w,
    input  logic [tsu_pkg::PW-1:0]          half,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [tsu_pkg::LINE_W-1:0]      in_line,
    input  logic signed [tsu_pkg::HW_W-1:0] in_nhw,
    input  logic [tsu_pkg::COL_W-1:0]       in_nn,
    input  logic [tsu_pkg::COL_W-1:0]       in_on,
    output logic                            job_valid,
    input  logic                            job_ready,
    output tsu_pkg::tsu_job_t               job
);

    localparam int unsigned PW     = tsu_pkg::PW;
    localparam int unsigned HW_W   = tsu_pkg::HW_W;
    localparam int unsigned COL_W  = tsu_pkg::COL_W;
    localparam int unsigned LINE_W = tsu_pkg::LINE_W;
    localparam int unsigned ADDR_W = (MAP_HEIGHT > 1) ? $clog2(MAP_HEIGHT) : 1;
    localparam int unsigned LX_W   = (ADDR_W > LINE_W) ? ADDR_W : LINE_W;

    // span table
    logic [HW_W-1:0] mem [MAP_HEIGHT];
    logic [HW_W-1:0] rdata_reg;

    // clearing pass after reset
    logic              clear_active_reg;
    logic [ADDR_W-1:0] clear_addr_reg;

    // stage 1: raw item, table read in flight
    logic                   s1_valid_reg;
    logic [LINE_W-1:0]      s1_line_reg;
    logic signed [HW_W-1:0] s1_nhw_reg;
    logic [COL_W-1:0]       s1_nn_reg;
    logic [COL_W-1:0]       s1_on_reg;
    logic                   fwd_hit_reg;
    logic [HW_W-1:0]        fwd_val_reg;

    // stage 2: clamped values
    logic              s2_valid_reg;
    logic [LINE_W-1:0] s2_line_reg;
    logic              s2_new_lit_reg;
    logic              s2_old_lit_reg;
    logic [PW-1:0]     s2_nw_reg;
    logic [PW-1:0]     s2_ow_reg;
    logic [PW-1:0]     s2_nn_reg;
    logic [PW-1:0]     s2_on_reg;

    // stage 3: span left edges
    logic              s3_valid_reg;
    logic [LINE_W-1:0] s3_line_reg;
    logic              s3_new_lit_reg;
    logic              s3_old_lit_reg;
    logic [PW-1:0]     s3_nw_reg;
    logic [PW-1:0]     s3_ow_reg;
    logic [PW-1:0]     s3_ol_reg;
    logic [PW-1:0]     s3_nl_reg;

    logic              accept;
    logic              s1_adv;
    logic              s2_adv;
    logic              s3_adv;
    logic [LX_W-1:0]   in_line_ext;
    logic [LX_W-1:0]   s1_line_ext;
    logic [ADDR_W-1:0] in_addr;
    logic [ADDR_W-1:0] s1_addr;
    logic              s1_in_range;
    logic              s1_wr;
    logic [HW_W-1:0]   stored;
    logic              new_dark;
    logic              old_dark;
    logic [PW-1:0]     nw_mag;
    logic [PW-1:0]     ow_mag;
    logic [PW-1:0]     nn_clamp;
    logic [PW-1:0]     on_clamp;
    logic [HW_W-1:0]   s1_wr_val;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [HW_W-1:0]   mem_wdata;
    logic [PW-1:0]     sum_o;
    logic [PW-1:0]     sum_n;
    logic [PW-1:0]     ol;
    logic [PW-1:0]     nl;
    logic [PW-1:0]     oe;
    logic [PW-1:0]     ne;
    logic              full_span;
    logic              disjoint;
    logic [PW-1:0]     cand_left [4];
    logic [PW-1:0]     cand_npix [4];
    logic [3:0]        cand_ok;
    logic [1:0]        cnt;
    logic [PW-1:0]     slot_left [2];
    logic [PW-1:0]     slot_npix [2];

    // pipeline flow
    always_comb
    begin
        s3_adv   = !s3_valid_reg || job_ready || (cnt == 2'd0);
        s2_adv   = !s2_valid_reg || s3_adv;
        s1_adv   = !s1_valid_reg || s2_adv;
        in_ready = !clear_active_reg && s1_adv;
        accept   = in_valid && in_ready;
    end

    // table addressing
    always_comb
    begin
        in_line_ext = LX_W'(in_line);
        s1_line_ext = LX_W'(s1_line_reg);
        in_addr     = in_line_ext[ADDR_W-1:0];
        s1_addr     = s1_line_ext[ADDR_W-1:0];
        s1_in_range = 32'(s1_line_reg) < 32'(MAP_HEIGHT);
        s1_wr       = s1_valid_reg && s1_adv && s1_in_range;
    end

    // clamp new and stored half-widths and the noon columns
    always_comb
    begin
        stored   = fwd_hit_reg ? fwd_val_reg : rdata_reg;
        new_dark = s1_nhw_reg[HW_W-1];
        old_dark = stored[HW_W-1];
        if (32'(s1_nhw_reg[HW_W-2:0]) > 32'(half))
        begin
            nw_mag = half;
        end
        else
        begin
            nw_mag = PW'(s1_nhw_reg[HW_W-2:0]);
        end
        if (32'(stored[HW_W-2:0]) > 32'(half))
        begin
            ow_mag = half;
        end
        else
        begin
            ow_mag = PW'(stored[HW_W-2:0]);
        end
        nn_clamp  = (32'(s1_nn_reg) >= 32'(w)) ? w - PW'(1) : PW'(s1_nn_reg);
        on_clamp  = (32'(s1_on_reg) >= 32'(w)) ? w - PW'(1) : PW'(s1_on_reg);
        s1_wr_val = new_dark ? {HW_W{1'b1}} : HW_W'(nw_mag);
    end

    // table write port: clearing pass or line update
    always_comb
    begin
        mem_we    = clear_active_reg || s1_wr;
        mem_waddr = clear_active_reg ? clear_addr_reg : s1_addr;
        mem_wdata = clear_active_reg ? {HW_W{1'b1}} : s1_wr_val;
    end

    // span table storage with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            rdata_reg <= mem[in_addr];
        end
    end

    // left edges of old and new spans, reduced below the width
    always_comb
    begin
        sum_o = s2_on_reg + w - s2_ow_reg;
        sum_n = s2_nn_reg + w - s2_nw_reg;
        ol    = (sum_o >= w) ? sum_o - w : sum_o;
        nl    = (sum_n >= w) ? sum_n - w : sum_n;
    end

    // classify into candidate runs in emission order
    always_comb
    begin
        oe        = s3_ol_reg + {s3_ow_reg[PW-2:0], 1'b0};
        ne        = s3_nl_reg + {s3_nw_reg[PW-2:0], 1'b0};
        full_span = (s3_ow_reg == half) && (s3_nw_reg == half);
        disjoint  = (oe <= s3_nl_reg) || (ne <= s3_ol_reg);
        cand_ok   = 4'b0000;
        for (int i = 0; i < 4; i++)
        begin
            cand_left[i] = '0;
            cand_npix[i] = '0;
        end
        priority if (!s3_new_lit_reg && !s3_old_lit_reg)
        begin
            cand_ok = 4'b0000;
        end
        else if (!s3_new_lit_reg)
        begin
            // line goes dark: erase old span
            cand_left[0] = s3_ol_reg;
            cand_npix[0] = {s3_ow_reg[PW-2:0], 1'b0};
            cand_ok[0]   = s3_ow_reg != '0;
        end
        else if (!s3_old_lit_reg)
        begin
            // line lights up: draw new span
            cand_left[0] = s3_nl_reg;
            cand_npix[0] = {s3_nw_reg[PW-2:0], 1'b0};
            cand_ok[0]   = s3_nw_reg != '0;
        end
        else if (full_span)
        begin
            cand_ok = 4'b0000;
        end
        else if (disjoint)
        begin
            // erase old, draw new
            cand_left[0] = s3_ol_reg;
            cand_npix[0] = {s3_ow_reg[PW-2:0], 1'b0};
            cand_ok[0]   = s3_ow_reg != '0;
            cand_left[1] = s3_nl_reg;
            cand_npix[1] = {s3_nw_reg[PW-2:0], 1'b0};
            cand_ok[1]   = s3_nw_reg != '0;
        end
        else
        begin
            // overlap: trim left, trim right, extend left, extend right
            cand_left[0] = s3_ol_reg;
            cand_npix[0] = s3_nl_reg - s3_ol_reg;
            cand_ok[0]   = s3_ol_reg < s3_nl_reg;
            cand_left[1] = ne;
            cand_npix[1] = oe - ne;
            cand_ok[1]   = oe > ne;
            cand_left[2] = s3_nl_reg;
            cand_npix[2] = s3_ol_reg - s3_nl_reg;
            cand_ok[2]   = s3_nl_reg < s3_ol_reg;
            cand_left[3] = oe;
            cand_npix[3] = ne - oe;
            cand_ok[3]   = ne > oe;
        end
    end

    // pack valid candidates into two slots
    always_comb
    begin
        cnt          = 2'd0;
        slot_left[0] = '0;
        slot_npix[0] = '0;
        slot_left[1] = '0;
        slot_npix[1] = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (cand_ok[i])
            begin
                if (cnt == 2'd0)
                begin
                    slot_left[0] = cand_left[i];
                    slot_npix[0] = cand_npix[i];
                    cnt          = 2'd1;
                end
                else
                begin
                    slot_left[1] = cand_left[i];
                    slot_npix[1] = cand_npix[i];
                    cnt          = 2'd2;
                end
            end
        end
    end

    // job to the queue
    always_comb
    begin
        job_valid = s3_valid_reg && (cnt != 2'd0);
        job.line  = s3_line_reg;
        job.left0 = slot_left[0];
        job.npix0 = slot_npix[0];
        job.left1 = slot_left[1];
        job.npix1 = slot_npix[1];
        job.two   = cnt == 2'd2;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            fwd_hit_reg      <= 1'b0;
        end
        else
        begin
            if (clear_active_reg)
            begin
                if (clear_addr_reg == ADDR_W'(MAP_HEIGHT - 1))
                begin
                    clear_active_reg <= 1'b0;
                end
                else
                begin
                    clear_addr_reg <= clear_addr_reg + ADDR_W'(1);
                end
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= s1_wr && (s1_line_reg == in_line);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_valid_reg && s1_in_range;
            end
            if (s3_adv)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_line_reg <= in_line;
            s1_nhw_reg  <= in_nhw;
            s1_nn_reg   <= in_nn;
            s1_on_reg   <= in_on;
            fwd_val_reg <= s1_wr_val;
        end
        if (s2_adv)
        begin
            s2_line_reg    <= s1_line_reg;
            s2_new_lit_reg <= !new_dark;
            s2_old_lit_reg <= !old_dark;
            s2_nw_reg      <= new_dark ? '0 : nw_mag;
            s2_ow_reg      <= old_dark ? '0 : ow_mag;
            s2_nn_reg      <= nn_clamp;
            s2_on_reg      <= on_clamp;
        end
        if (s3_adv)
        begin
            s3_line_reg    <= s2_line_reg;
            s3_new_lit_reg <= s2_new_lit_reg;
            s3_old_lit_reg <= s2_old_lit_reg;
            s3_nw_reg      <= s2_nw_reg;
            s3_ow_reg      <= s2_ow_reg;
            s3_ol_reg      <= ol;
            s3_nl_reg      <= nl;
        end
    end

endmodule

[sv/tsu_queue.sv]
// short job queue between front and back
module tsu_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  tsu_pkg::tsu_job_t push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output tsu_pkg::tsu_job_t pop_data
);

    localparam int unsigned DEPTH = tsu_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    tsu_pkg::tsu_job_t slots [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              push;
    logic              pop;

    // handshake
    always_comb
    begin
        push_ready = count_reg != CNT_W'(DEPTH);
        pop_valid  = count_reg != '0;
        push       = push_valid && push_ready;
        pop        = pop_valid && pop_ready;
        pop_data   = slots[rd_ptr_reg];
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[sv/tsu_back.sv]
// back end: splits runs at the right edge and emits one segment per cycle while the output is not stalled
module tsu_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [tsu_pkg::PW-1:0]               w,
    input  logic                                 job_valid,
    output logic                                 job_ready,
    input  tsu_pkg::tsu_job_t                    job,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [tsu_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic                                 m_tlast
);

    localparam int unsigned PW    = tsu_pkg::PW;
    localparam int unsigned COL_W = tsu_pkg::COL_W;
    localparam int unsigned PAD_W = tsu_pkg::OUT_DATA_W - tsu_pkg::LINE_W - 2 * COL_W;

    typedef enum logic [1:0] {ST_RUN0, ST_RUN0_WRAP, ST_RUN1, ST_RUN1_WRAP} state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic                       out_valid_reg;
    logic [tsu_pkg::LINE_W-1:0] out_line_reg;
    logic [COL_W-1:0]           out_start_reg;
    logic [COL_W-1:0]           out_end_reg;
    logic                       out_last_reg;

    logic          second_run;
    logic          wrap_phase;
    logic [PW-1:0] left;
    logic [PW-1:0] npix;
    logic [PW-1:0] left_r;
    logic [PW:0]   endx;
    logic          split;
    logic [PW:0]   seg_start;
    logic [PW:0]   seg_end;
    logic          run_done;
    logic          job_done;
    logic          out_adv;
    logic          emit;

    // current run and its wrap split
    always_comb
    begin
        second_run = (state_reg == ST_RUN1) || (state_reg == ST_RUN1_WRAP);
        wrap_phase = (state_reg == ST_RUN0_WRAP) || (state_reg == ST_RUN1_WRAP);
        left       = second_run ? job.left1 : job.left0;
        npix       = second_run ? job.npix1 : job.npix0;
        left_r     = (left >= w) ? left - w : left;
        endx       = {1'b0, left_r} + {1'b0, npix};
        split      = endx > {1'b0, w};
        if (wrap_phase)
        begin
            seg_start = '0;
            seg_end   = endx - {1'b0, w} - (PW + 1)'(1);
        end
        else
        begin
            seg_start = {1'b0, left_r};
            seg_end   = split ? {1'b0, w} - (PW + 1)'(1) : endx - (PW + 1)'(1);
        end
        run_done  = wrap_phase || !split;
        job_done  = run_done && (second_run || !job.two);
        out_adv   = !out_valid_reg || m_tready;
        emit      = job_valid && out_adv;
        job_ready = emit && job_done;
    end

    // next segment selection
    always_comb
    begin
        state_next = state_reg;
        if (emit)
        begin
            unique case (state_reg)
                ST_RUN0:
                begin
                    if (job_done)
                    begin
                        state_next = ST_RUN0;
                    end
                    else if (!run_done)
                    begin
                        state_next = ST_RUN0_WRAP;
                    end
                    else
                    begin
                        state_next = ST_RUN1;
                    end
                end
                ST_RUN0_WRAP:
                begin
                    state_next = job_done ? ST_RUN0 : ST_RUN1;
                end
                ST_RUN1:
                begin
                    state_next = job_done ? ST_RUN0 : ST_RUN1_WRAP;
                end
                ST_RUN1_WRAP:
                begin
                    state_next = ST_RUN0;
                end
                default:
                begin
                    state_next = ST_RUN0;
                end
            endcase
        end
    end

    // state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN0;
            out_valid_reg <= 1'b0;
            out_line_reg  <= '0;
            out_start_reg <= '0;
            out_end_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
                out_line_reg  <= job.line;
                out_start_reg <= seg_start[COL_W-1:0];
                out_end_reg   <= seg_end[COL_W-1:0];
                out_last_reg  <= job_done;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result port
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {PAD_W'(0), out_end_reg, out_start_reg, out_line_reg};
    assign m_tlast  = out_last_reg;

endmodule

[sv/terminator_span_update_top.sv]
// Terminator span update top level. Each input transaction names one map line with its new lit
// half-width and the new and old noon columns; the block compares it with the half-width stored
// for that line and returns 0 to 4 segments (line, first column, last column) to invert, the
// final one of each line marked by m_tlast. A three-stage front end reads and updates the span
// table and classifies the line, a four-entry job queue follows, and the back end emits one
// segment per cycle from a registered output while m_tready does not stall it. Input
// transactions are taken one per cycle unless the pipeline is held by back-pressure from the
// single segment output of the back end. After reset the span table is cleared to dark in a pass
// over all MAP_HEIGHT lines (512 by default) during which s_tready stays low; map_width writes
// are taken at any time and apply from the next cycle.
module terminator_span_update_top #(
    parameter int unsigned MAP_HEIGHT = tsu_pkg::MAP_HEIGHT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tsu_pkg::CFG_W-1:0]        cfg_data,    // map_width
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tsu_pkg::IN_DATA_W-1:0]    s_tdata,     // line_index, new_half_width, new_noon, old_noon
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tsu_pkg::OUT_DATA_W-1:0]   m_tdata,     // seg_line, seg_start, seg_end
    output logic                             m_tlast      // seg_last
);

    localparam int unsigned PW = tsu_pkg::PW;

    logic [PW-1:0]                   w_reg;
    logic [PW-1:0]                   half;
    logic signed [tsu_pkg::HW_W-1:0] in_nhw;
    logic                            fq_valid;
    logic                            fq_ready;
    tsu_pkg::tsu_job_t               fq_job;
    logic                            qb_valid;
    logic                            qb_ready;
    tsu_pkg::tsu_job_t               qb_job;

    // effective map width, clamped at write time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= PW'(tsu_pkg::MAP_WIDTH_RESET);
        end
        else if (cfg_we)
        begin
            priority if (32'(cfg_data) < tsu_pkg::MIN_MAP_WIDTH)
            begin
                w_reg <= PW'(tsu_pkg::MIN_MAP_WIDTH);
            end
            else if (32'(cfg_data) > tsu_pkg::MAX_MAP_WIDTH)
            begin
                w_reg <= PW'(tsu_pkg::MAX_MAP_WIDTH);
            end
            else
            begin
                w_reg <= PW'(cfg_data);
            end
        end
    end

    assign half   = w_reg >> 1;
    assign in_nhw = s_tdata[19:9];

    // line classification
    tsu_front #(
        .MAP_HEIGHT(MAP_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .w        (w_reg),
        .half     (half),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_line  (s_tdata[8:0]),
        .in_nhw   (in_nhw),
        .in_nn    (s_tdata[29:20]),
        .in_on    (s_tdata[39:30]),
        .job_valid(fq_valid),
        .job_ready(fq_ready),
        .job      (fq_job)
    );

    // job queue
    tsu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(fq_valid),
        .push_ready(fq_ready),
        .push_data (fq_job),
        .pop_valid (qb_valid),
        .pop_ready (qb_ready),
        .pop_data  (qb_job)
    );

    // segment emission
    tsu_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .w        (w_reg),
        .job_valid(qb_valid),
        .job_ready(qb_ready),
        .job      (qb_job),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

[sv/tsu_checker.sv]
// port-level checks of the terminator span update block and their binding
`include "terminator_span_update_top_defines.svh"

module tsu_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tsu_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           m_tlast
);

    // a stalled segment holds
    `TSU_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled segment changed")

    // table clearing keeps the input closed right after reset
    `TSU_ASSERT_IMP(a_clear_blocks_input, clk, rst_n, !$past(rst_n), !s_tready, "input open during table clearing")

    // the rest of a line follows without a gap
    `TSU_ASSERT_NXT(a_line_no_gap, clk, rst_n, m_tvalid && m_tready && !m_tlast, m_tvalid, "gap inside a line's segments")

    // segments of one line share the line number
    `TSU_ASSERT_NXT(a_line_same, clk, rst_n, m_tvalid && m_tready && !m_tlast, m_tdata[8:0] == $past(m_tdata[8:0]), "line changed inside a line's segments")

    // a segment never runs backward
    `TSU_ASSERT_IMP(a_seg_order, clk, rst_n, m_tvalid, m_tdata[28:19] >= m_tdata[18:9], "segment end before start")

endmodule

bind terminator_span_update_top tsu_checker u_tsu_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);
